### hdl/wls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wls_pkg;

    localparam int ERROR_DEPTH_DEF = 8;
    localparam int WINDOW_LIMIT    = 8;
    localparam int FRAME_SLOTS     = 16;
    localparam int QUEUE_DEPTH     = 2;

    // frame positions: cursor (8 bits) plus window offset
    localparam int POS_W = 9;

    typedef logic [2:0] op_t;
    localparam op_t OP_BLOCK = 3'd0;
    localparam op_t OP_INFO  = 3'd1;
    localparam op_t OP_ACK   = 3'd2;
    localparam op_t OP_SEND  = 3'd3;
    localparam op_t OP_SAVE  = 3'd4;

    localparam logic [1:0] RES_DATA    = 2'd0;
    localparam logic [1:0] RES_ERROR   = 2'd1;
    localparam logic [1:0] RES_NOTHING = 2'd2;
    localparam logic [1:0] RES_STATUS  = 2'd3;

    localparam logic [1:0] SENT_NOTHING = 2'd0;
    localparam logic [1:0] SENT_ERROR   = 2'd1;
    localparam logic [1:0] SENT_DATA    = 2'd2;

    localparam logic [0:0] REG_FRAMES_IN_BLOCK = 1'b0;
    localparam logic [0:0] REG_LAST_BLOCK      = 1'b1;

    typedef struct packed {
        op_t        op;
        logic [7:0] msg_id;
        logic       wait_expired;
        logic [7:0] error_code;
    } cmd_t;

    typedef struct packed {
        logic [4:0] frames_in_block;
        logic [7:0] last_block;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/wls_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wls_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,  // msg_id, wait_expired, error_code, zero pad
    input  wire logic [2:0]    s_tuser,  // kind
    output logic               q_valid,
    output wls_pkg::cmd_t      q_cmd,
    input  wire logic          q_pop
);

    localparam int QPTR_W = $clog2(wls_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(wls_pkg::QUEUE_DEPTH + 1);

    wls_pkg::cmd_t q_mem_reg [wls_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    wls_pkg::cmd_t cmd_in;
    logic          kind_ok;
    logic          push;

    // classify; unknown kinds are dropped here
    always_comb
    begin
        cmd_in.op           = s_tuser;
        cmd_in.msg_id       = s_tdata[7:0];
        cmd_in.wait_expired = s_tdata[8];
        cmd_in.error_code   = s_tdata[16:9];
        unique case (s_tuser)
            wls_pkg::OP_BLOCK,
            wls_pkg::OP_INFO,
            wls_pkg::OP_ACK,
            wls_pkg::OP_SEND,
            wls_pkg::OP_SAVE: kind_ok = 1'b1;
            default:          kind_ok = 1'b0;
        endcase
    end

    assign s_tready = (count_reg < QCNT_W'(wls_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && kind_ok;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(wls_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(wls_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("queue popped while empty");

endmodule

`default_nettype wire

### hdl/wls_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wls_back #(
    parameter int ERROR_DEPTH = wls_pkg::ERROR_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wls_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    input  wire wls_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,  // frame_id, remaining, payload_index, send_next, pad
    output logic [1:0]         m_tuser,  // item_kind
    output logic               m_tlast
);

    localparam int PTR_W = (ERROR_DEPTH > 1) ? $clog2(ERROR_DEPTH) : 1;
    localparam int POS_W = wls_pkg::POS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INFO = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [7:0] err_mem [ERROR_DEPTH];

    logic [1:0]       state_reg, state_next;
    logic [7:0]       cursor_reg, cursor_next;
    logic [7:0]       ack_exp_reg, ack_exp_next;
    logic [3:0]       window_reg, window_next;
    logic [7:0]       cur_blk_reg, cur_blk_next;
    logic [1:0]       sent_reg, sent_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic             ovr_reg, ovr_next;
    logic             out_valid_reg, out_valid_next;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       rem_reg, rem_next;
    logic             has_reg, has_next;
    logic [7:0]       rd_data_reg;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_id_reg, out_id_next;
    logic [3:0]       out_rem_reg, out_rem_next;
    logic [3:0]       out_pidx_reg, out_pidx_next;
    logic             out_nxt_reg, out_nxt_next;
    logic             out_last_reg, out_last_next;

    logic             can_out;
    logic             mem_we;
    logic             rd_en;
    logic [POS_W-1:0] nfr;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] pos_inc;
    logic             has_entry;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W-1:0] wp_inc;
    logic [3:0]       end_rem;
    logic [7:0]       err_val;
    logic             frame_last;

    assign can_out   = !out_valid_reg || m_tready;
    assign nfr       = (cfg.frames_in_block > 5'(wls_pkg::FRAME_SLOTS))
                       ? POS_W'(wls_pkg::FRAME_SLOTS)
                       : POS_W'(cfg.frames_in_block);
    assign start     = (cursor_reg == 8'd0) ? POS_W'(1) : POS_W'(cursor_reg);
    assign pos_inc   = pos_reg + 1'b1;
    assign has_entry = (rp_reg != wp_reg) || ovr_reg;
    assign rp_inc    = (rp_reg == PTR_W'(ERROR_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign wp_inc    = (wp_reg == PTR_W'(ERROR_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign end_rem   = (cur_blk_reg >= cfg.last_block) ? 4'(wls_pkg::WINDOW_LIMIT + 1)
                                                       : 4'(wls_pkg::WINDOW_LIMIT);
    assign err_val   = has_reg ? rd_data_reg : 8'd0;
    assign frame_last = (rem_reg == 4'd1) || (pos_inc == nfr);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        ack_exp_next   = ack_exp_reg;
        window_next    = window_reg;
        cur_blk_next   = cur_blk_reg;
        sent_next      = sent_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        ovr_next       = ovr_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        has_next       = has_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_rem_next   = out_rem_reg;
        out_pidx_next  = out_pidx_reg;
        out_nxt_next   = out_nxt_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_out)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        wls_pkg::OP_BLOCK:
                        begin
                            out_nxt_next = 1'b0;
                            if (q_cmd.msg_id <= cfg.last_block)
                            begin
                                out_nxt_next = 1'b1;
                                if (q_cmd.msg_id != cur_blk_reg)
                                begin
                                    cur_blk_next = q_cmd.msg_id;
                                    cursor_next  = 8'd1;
                                    window_next  = 4'd1;
                                end
                            end
                            out_valid_next = 1'b1;
                            out_kind_next  = wls_pkg::RES_STATUS;
                            out_id_next    = 8'd0;
                            out_rem_next   = 4'd0;
                            out_pidx_next  = 4'd0;
                            out_last_next  = 1'b1;
                        end
                        wls_pkg::OP_INFO:
                        begin
                            rd_en      = 1'b1;
                            has_next   = has_entry;
                            state_next = ST_INFO;
                        end
                        wls_pkg::OP_ACK:
                        begin
                            out_nxt_next = 1'b0;
                            if (sent_reg == wls_pkg::SENT_ERROR)
                            begin
                                if (has_entry)
                                begin
                                    rp_next  = rp_inc;
                                    ovr_next = 1'b0;
                                end
                            end
                            else if (sent_reg == wls_pkg::SENT_DATA)
                            begin
                                cursor_next = q_cmd.msg_id;
                                if (q_cmd.msg_id == ack_exp_reg)
                                begin
                                    window_next = 4'(wls_pkg::WINDOW_LIMIT - 1);
                                end
                                else if (q_cmd.wait_expired && (window_reg > 4'd1))
                                begin
                                    window_next = window_reg >> 1;
                                end
                                out_nxt_next = (POS_W'(q_cmd.msg_id) <= nfr);
                            end
                            out_valid_next = 1'b1;
                            out_kind_next  = wls_pkg::RES_STATUS;
                            out_id_next    = 8'd0;
                            out_rem_next   = 4'd0;
                            out_pidx_next  = 4'd0;
                            out_last_next  = 1'b1;
                        end
                        wls_pkg::OP_SEND:
                        begin
                            sent_next = wls_pkg::SENT_DATA;
                            if ((window_reg != 4'd0) && ((start - 1'b1) < nfr))
                            begin
                                pos_next   = start - 1'b1;
                                rem_next   = window_reg;
                                state_next = ST_SEND;
                            end
                            else
                            begin
                                ack_exp_next = start[7:0];
                            end
                        end
                        wls_pkg::OP_SAVE:
                        begin
                            mem_we  = 1'b1;
                            wp_next = wp_inc;
                            if (ovr_reg)
                            begin
                                rp_next = rp_inc;
                            end
                            if (wp_inc == (ovr_reg ? rp_inc : rp_reg))
                            begin
                                ovr_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INFO:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    out_rem_next   = 4'd1;
                    out_pidx_next  = 4'd0;
                    out_nxt_next   = 1'b0;
                    out_last_next  = 1'b1;
                    if ((err_val != 8'd0) && !err_val[7])
                    begin
                        out_kind_next = wls_pkg::RES_ERROR;
                        out_id_next   = err_val;
                        sent_next     = wls_pkg::SENT_ERROR;
                    end
                    else
                    begin
                        out_kind_next = wls_pkg::RES_NOTHING;
                        out_id_next   = 8'd1;
                        sent_next     = wls_pkg::SENT_NOTHING;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = wls_pkg::RES_DATA;
                    out_id_next    = pos_inc[7:0];
                    out_rem_next   = (pos_inc == nfr) ? end_rem : rem_reg;
                    out_pidx_next  = pos_reg[3:0];
                    out_nxt_next   = 1'b0;
                    out_last_next  = frame_last;
                    pos_next       = pos_inc;
                    rem_next       = rem_reg - 1'b1;
                    if (frame_last)
                    begin
                        ack_exp_next = 8'(pos_reg + POS_W'(2));
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= 8'd1;
            ack_exp_reg   <= 8'd1;
            window_reg    <= 4'd1;
            cur_blk_reg   <= 8'd0;
            sent_reg      <= wls_pkg::SENT_NOTHING;
            rp_reg        <= '0;
            wp_reg        <= '0;
            ovr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            ack_exp_reg   <= ack_exp_next;
            window_reg    <= window_next;
            cur_blk_reg   <= cur_blk_next;
            sent_reg      <= sent_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            ovr_reg       <= ovr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        has_reg      <= has_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_rem_reg  <= out_rem_next;
        out_pidx_reg <= out_pidx_next;
        out_nxt_reg  <= out_nxt_next;
        out_last_reg <= out_last_next;
    end

    // error ring storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            err_mem[wp_reg] <= q_cmd.error_code;
        end
        if (rd_en)
        begin
            rd_data_reg <= err_mem[rp_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_nxt_reg, out_pidx_reg, out_rem_reg, out_id_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        ovr_reg |-> (rp_reg == wp_reg))
        else $error("ring full flag set with unequal pointers");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> ((rem_reg != 4'd0) && (pos_reg < nfr)))
        else $error("send burst running past window or block");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (can_out && (state_reg == ST_IDLE)))
        else $error("request taken while back end busy");

endmodule

`default_nettype wire

### hdl/windowed_log_sender_with_error_ring.sv
// A block request or an ack goes from the queue straight into the output register; an
// info request passes the error store read register, then the output register; a send
// of at most seven frames first loads its start position, then writes one frame per
// cycle while the output is not stalled. Requests enter a two-entry queue at one per
// cycle while it has room; the back end takes no new request during an info request or send.
// Reset (rst_n, async): queue empty, cursor, ack and window 1, block 0; store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module windowed_log_sender_with_error_ring #(
    parameter int ERROR_DEPTH = wls_pkg::ERROR_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // msg_id[7:0], wait_expired[8], error_code[16:9]
    input  wire logic [2:0]  s_tuser,  // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // frame_id[7:0], remaining[11:8],
                                       // payload_index[15:12], send_next[16]
    output logic [1:0]       m_tuser,  // item_kind
    output logic             m_tlast,  // last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [4:0]    fib_reg;
    logic [7:0]    lb_reg;
    logic          wr_en;
    wls_pkg::cfg_t cfg;
    wls_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fib_reg <= 5'd16;
            lb_reg  <= 8'd8;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                wls_pkg::REG_FRAMES_IN_BLOCK: fib_reg <= pwdata[4:0];
                wls_pkg::REG_LAST_BLOCK:      lb_reg  <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign prdata = (paddr[2] == wls_pkg::REG_LAST_BLOCK) ? {24'd0, lb_reg} : {27'd0, fib_reg};

    assign cfg.frames_in_block = fib_reg;
    assign cfg.last_block      = lb_reg;

    wls_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    wls_back #(
        .ERROR_DEPTH (ERROR_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
